// ===== hw/rtl/kts_pkg.sv =====
// ----------------------------------------------------------------------------
// kts_pkg: keyword token spotter shared definitions
// Keyword table, delimiter classification and common widths.
// ----------------------------------------------------------------------------
package kts_pkg;

    localparam int CHAR_W   = 8;
    localparam int KW_COUNT = 22;
    localparam int KW_BYTES = 8;
    localparam int KW_LEN_W = 4;
    localparam int ID_W     = 5;

    typedef enum logic [ID_W-1:0] {
        KW_IF       = 5'd0,
        KW_ELSE     = 5'd1,
        KW_WHILE    = 5'd2,
        KW_DO       = 5'd3,
        KW_BREAK    = 5'd4,
        KW_CONTINUE = 5'd5,
        KW_INT      = 5'd6,
        KW_DOUBLE   = 5'd7,
        KW_FLOAT    = 5'd8,
        KW_RETURN   = 5'd9,
        KW_CHAR     = 5'd10,
        KW_CASE     = 5'd11,
        KW_SIZEOF   = 5'd12,
        KW_LONG     = 5'd13,
        KW_SHORT    = 5'd14,
        KW_TYPEDEF  = 5'd15,
        KW_SWITCH   = 5'd16,
        KW_UNSIGNED = 5'd17,
        KW_VOID     = 5'd18,
        KW_STATIC   = 5'd19,
        KW_STRUCT   = 5'd20,
        KW_GOTO     = 5'd21
    } t_kw_id;

    // Keyword text with the first character in the lowest byte
    // (literals are written back to front for that reason).
    function automatic logic [KW_BYTES*CHAR_W-1:0] kw_text(input t_kw_id k);
        logic [KW_BYTES*CHAR_W-1:0] t;
        case (k)
            KW_IF:       t = 64'("fi");
            KW_ELSE:     t = 64'("esle");
            KW_WHILE:    t = 64'("elihw");
            KW_DO:       t = 64'("od");
            KW_BREAK:    t = 64'("kaerb");
            KW_CONTINUE: t = 64'("eunitnoc");
            KW_INT:      t = 64'("tni");
            KW_DOUBLE:   t = 64'("elbuod");
            KW_FLOAT:    t = 64'("taolf");
            KW_RETURN:   t = 64'("nruter");
            KW_CHAR:     t = 64'("rahc");
            KW_CASE:     t = 64'("esac");
            KW_SIZEOF:   t = 64'("foezis");
            KW_LONG:     t = 64'("gnol");
            KW_SHORT:    t = 64'("trohs");
            KW_TYPEDEF:  t = 64'("fedepyt");
            KW_SWITCH:   t = 64'("hctiws");
            KW_UNSIGNED: t = 64'("dengisnu");
            KW_VOID:     t = 64'("diov");
            KW_STATIC:   t = 64'("citats");
            KW_STRUCT:   t = 64'("tcurts");
            KW_GOTO:     t = 64'("otog");
            default:     t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [KW_LEN_W-1:0] kw_len(input t_kw_id k);
        logic [KW_LEN_W-1:0] n;
        case (k)
            KW_IF, KW_DO:                                    n = 4'd2;
            KW_INT:                                          n = 4'd3;
            KW_ELSE, KW_CHAR, KW_CASE, KW_LONG, KW_VOID,
            KW_GOTO:                                         n = 4'd4;
            KW_WHILE, KW_BREAK, KW_FLOAT, KW_SHORT:          n = 4'd5;
            KW_DOUBLE, KW_RETURN, KW_SIZEOF, KW_SWITCH,
            KW_STATIC, KW_STRUCT:                            n = 4'd6;
            KW_TYPEDEF:                                      n = 4'd7;
            KW_CONTINUE, KW_UNSIGNED:                        n = 4'd8;
            default:                                         n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic is_delim(input logic [CHAR_W-1:0] c);
        logic d;
        case (c)
            " ", "+", "-", "*", "/", ",", ";", ">",
            "<", "=", "(", ")", "[", "]", "{", "}": d = 1'b1;
            default:                               d = 1'b0;
        endcase
        return d;
    endfunction

endpackage

// ===== hw/rtl/kts_front.sv =====
// ----------------------------------------------------------------------------
// kts_front: character intake and token assembly
// Classifies each character, builds the pending token and pushes every
// finished, non-empty, non-overflowed token into the token queue.
// ----------------------------------------------------------------------------
module kts_front #(
    parameter int MAX_TOKEN = 8,
    parameter int CNT_W     = $clog2(MAX_TOKEN + 1)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [kts_pkg::CHAR_W-1:0]            i_char_code,
    input  logic                                  i_line_end,
    input  logic                                  i_full,
    output logic                                  o_push,
    output logic [MAX_TOKEN*kts_pkg::CHAR_W-1:0]  o_chars,
    output logic [CNT_W-1:0]                      o_len
);
    import kts_pkg::*;

    logic [MAX_TOKEN-1:0][CHAR_W-1:0] r_chars, n_chars;
    logic [CNT_W-1:0]                 r_count, n_count;
    logic                             r_ovf,   n_ovf;
    logic                             accept, delim, append, grow_ovf, finish;
    logic [CNT_W-1:0]                 grow_count;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign delim   = is_delim(i_char_code);
    assign append  = !delim && (r_count < CNT_W'(MAX_TOKEN));

    always_comb begin
        n_chars = r_chars;
        for (int j = 0; j < MAX_TOKEN; j++) begin
            if (append && (r_count == CNT_W'(j))) begin
                n_chars[j] = i_char_code;
            end
        end
    end

    assign grow_count = append ? r_count + CNT_W'(1) : r_count;
    assign grow_ovf   = r_ovf || (!delim && !append);

    // A delimiter ends the held token; otherwise a line end ends the grown one.
    always_comb begin
        if (delim) begin
            finish = (r_count != '0) && !r_ovf;
            o_len  = r_count;
        end else begin
            finish = i_line_end && (grow_count != '0) && !grow_ovf;
            o_len  = grow_count;
        end
        if (delim || i_line_end) begin
            n_count = '0;
            n_ovf   = 1'b0;
        end else begin
            n_count = grow_count;
            n_ovf   = grow_ovf;
        end
    end

    assign o_push  = accept && finish;
    assign o_chars = n_chars;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (accept) begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_chars <= n_chars;
        end
    end

endmodule

// ===== hw/rtl/kts_queue.sv =====
// ----------------------------------------------------------------------------
// kts_queue: two-entry token queue
// Decouples token assembly from keyword matching.
// ----------------------------------------------------------------------------
module kts_queue #(
    parameter int WIDTH = 72
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    logic [1:0][WIDTH-1:0] r_mem;
    logic                  r_wr, r_rd;
    logic [1:0]            r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/kts_back.sv =====
// ----------------------------------------------------------------------------
// kts_back: keyword match and result register
// Compares a finished token against all keywords at once and holds a hit
// in the output register until it is taken.
// ----------------------------------------------------------------------------
module kts_back #(
    parameter int MAX_TOKEN = 8,
    parameter int CNT_W     = $clog2(MAX_TOKEN + 1)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_empty,
    input  logic [MAX_TOKEN*kts_pkg::CHAR_W-1:0]  i_chars,
    input  logic [CNT_W-1:0]                      i_len,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [kts_pkg::ID_W-1:0]              o_keyword_id
);
    import kts_pkg::*;

    logic                      r_valid;
    logic [ID_W-1:0]           r_id;
    logic                      hit;
    logic [ID_W-1:0]           hit_id;
    logic [KW_BYTES*CHAR_W-1:0] head;
    logic [KW_BYTES*CHAR_W-1:0] ref_txt;
    logic [KW_LEN_W-1:0]       ref_len;
    logic                      same;

    assign head  = i_chars[KW_BYTES*CHAR_W-1:0];
    assign o_pop = !i_empty && (!r_valid || i_ready);

    // Keywords are distinct, so at most one can match.
    always_comb begin
        hit     = 1'b0;
        hit_id  = '0;
        ref_txt = '0;
        ref_len = '0;
        same    = 1'b0;
        for (int k = 0; k < KW_COUNT; k++) begin
            ref_txt = kw_text(t_kw_id'(k));
            ref_len = kw_len(t_kw_id'(k));
            same    = (i_len == CNT_W'(ref_len));
            for (int j = 0; j < KW_BYTES; j++) begin
                if ((KW_LEN_W'(j) < ref_len) &&
                    (head[j*CHAR_W +: CHAR_W] != ref_txt[j*CHAR_W +: CHAR_W])) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                hit    = 1'b1;
                hit_id = ID_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= hit;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && hit) begin
            r_id <= hit_id;
        end
    end

    assign o_valid      = r_valid;
    assign o_keyword_id = r_id;

endmodule

// ===== hw/rtl/keyword_token_spotter.sv =====
// ----------------------------------------------------------------------------
// keyword_token_spotter: keyword recognition over a character stream
// Splits bytes into tokens and reports the index of each C keyword found.
// ----------------------------------------------------------------------------
// One character transaction is taken every clock cycle unless the token queue
// is full. Tokens end at one of sixteen delimiters or after a character flagged
// as line end; a token that equals a keyword yields its index after passing
// through the two-entry token queue and the result register. Tokens longer
// than MAX_TOKEN never match. Input stalls only when the token queue is full,
// which happens only while results are held back downstream.
module keyword_token_spotter #(
    parameter int MAX_TOKEN = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [kts_pkg::CHAR_W-1:0] i_char_code,
    input  logic                       i_line_end,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [kts_pkg::ID_W-1:0]   o_keyword_id
);
    import kts_pkg::*;

    localparam int CNT_W = $clog2(MAX_TOKEN + 1);
    localparam int TOK_W = MAX_TOKEN * CHAR_W;
    localparam int Q_W   = TOK_W + CNT_W;

    logic             push, pop, full, empty;
    logic [TOK_W-1:0] f_chars;
    logic [CNT_W-1:0] f_len;
    logic [Q_W-1:0]   q_out;

    kts_front #(
        .MAX_TOKEN (MAX_TOKEN),
        .CNT_W     (CNT_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_code (i_char_code),
        .i_line_end  (i_line_end),
        .i_full      (full),
        .o_push      (push),
        .o_chars     (f_chars),
        .o_len       (f_len)
    );

    kts_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_len, f_chars}),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (q_out)
    );

    kts_back #(
        .MAX_TOKEN (MAX_TOKEN),
        .CNT_W     (CNT_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_chars      (q_out[TOK_W-1:0]),
        .i_len        (q_out[Q_W-1:TOK_W]),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_keyword_id (o_keyword_id)
    );

endmodule
